/* src/brl_pkg.sv */
// Shared constants and types for the beat repeat loop.
// No dependencies; imported by the top level.
package brl_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned FPB_W      = 18;
  localparam int unsigned DIV_W      = 2;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned GAIN_FRAC  = 15;
  localparam int unsigned GAIN_EXT_W = GAIN_FRAC + 2;

  localparam logic [GAIN_W-1:0]     UNITY_GAIN = GAIN_W'(1 << GAIN_FRAC);
  localparam logic [FPB_W-1:0]      FPB_RESET  = FPB_W'(22050);
  localparam logic [DIV_W-1:0]      DIV_RESET  = '0;
  localparam logic [GAIN_W-1:0]     WET_RESET  = UNITY_GAIN;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_DIVISION = 2'd1,
    CFG_FPB      = 2'd2,
    CFG_WET      = 2'd3
  } cfg_idx_e;

endpackage

/* src/brl_in_if.sv */
// Input channel carrying one live sample per request.
// Depends on nothing.
interface brl_in_if #(parameter int unsigned SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

/* src/brl_out_if.sv */
// Output channel carrying one processed sample per request.
// Depends on nothing.
interface brl_out_if #(parameter int unsigned SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

/* src/brl_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module brl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/beat_repeat_loop.sv */
// Beat repeat (stutter) effect top level.
// Depends on brl_pkg, brl_in_if, brl_out_if and brl_ram.
//
// Usage:
//   Samples enter on in_ch and leave on out_ch, one result per request, in
//   order. Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while the block is idle: enable, division_code, frames_per_beat, wet_gain.
//   With enable low, samples pass through and recording re-arms. With enable
//   high, the first loop-length samples are recorded into the loop memory
//   and passed through; later samples are mixed with the recorded loop.
// Timing:
//   Accepted samples pass the s1, s2 and output registers. Throughput is one
//   sample per cycle unless out_ch stalls, set by the single loop memory read
//   or write per sample and the registered multiply and sum stages behind it.
// Reset:
//   Configuration takes its default values, recording is armed and both
//   counters clear. Loop memory contents are left as they are.
// Backpressure:
//   When the receiver stalls with a result held, the whole pipeline holds
//   and in_ch.ready drops in the same cycle.
module beat_repeat_loop
  import brl_pkg::*;
#(
  parameter int unsigned LOOP_DEPTH  = 32768,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  brl_in_if.sink                in_ch,
  brl_out_if.source             out_ch
);

  localparam int unsigned ADDR_W = $clog2(LOOP_DEPTH);
  localparam int unsigned CNT_W  = $clog2(LOOP_DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > FPB_W) ? CNT_W : FPB_W;
  localparam int unsigned PROD_W = SAMPLE_BITS + GAIN_EXT_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(LOOP_DEPTH);

  logic                  enable_q;
  logic [DIV_W-1:0]      div_q;
  logic [FPB_W-1:0]      fpb_q;
  logic [GAIN_W-1:0]     wet_q;

  logic [CNT_W-1:0]      rec_cnt_q, rec_cnt_d;
  logic                  recording_q, recording_d;
  logic [CNT_W-1:0]      play_idx_q, play_idx_d;

  logic                  advance;
  logic                  accept;

  logic [CMP_W-1:0]      len;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      limit_a, limit_b, limit;
  logic [CNT_W-1:0]      play_cur;
  logic                  rec_store;
  logic                  ram_we, ram_re;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic [GAIN_EXT_W-1:0] wet_eff, dry_eff;

  logic                          s1_valid_q, s1_mix_q;
  logic signed [SAMPLE_BITS-1:0] s1_live_q;
  logic [GAIN_EXT_W-1:0]         s1_wet_q, s1_dry_q;

  logic                          s2_valid_q, s2_mix_q;
  logic signed [SAMPLE_BITS-1:0] s2_live_q;
  logic signed [PROD_W-1:0]      s2_pwet_q, s2_pdry_q;

  logic signed [SUM_W-1:0]       mix_sum;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      div_q    <= DIV_RESET;
      fpb_q    <= FPB_RESET;
      wet_q    <= WET_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:   enable_q <= cfg_data_i[0];
        CFG_DIVISION: div_q    <= cfg_data_i[DIV_W-1:0];
        CFG_FPB:      fpb_q    <= cfg_data_i[FPB_W-1:0];
        CFG_WET:      wet_q    <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = !out_valid_q || out_ch.ready;
  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;

  // loop length and playback bound
  always_comb begin
    len = CMP_W'(fpb_q >> div_q);
    if (len == '0) begin
      len = CMP_W'(1);
    end
    cnt_ext = CMP_W'(rec_cnt_q);
    limit_a = (len < DEPTH_C) ? len : DEPTH_C;
    limit_b = (limit_a < cnt_ext) ? limit_a : cnt_ext;
    limit   = (limit_b == '0) ? CMP_W'(1) : limit_b;
    play_cur = (CMP_W'(play_idx_q) >= limit) ? '0 : play_idx_q;
    rec_store = (cnt_ext < DEPTH_C) && (cnt_ext < len);
  end

  always_comb begin
    rec_cnt_d   = rec_cnt_q;
    recording_d = recording_q;
    play_idx_d  = play_idx_q;
    if (accept) begin
      if (!enable_q) begin
        rec_cnt_d   = '0;
        recording_d = 1'b1;
        play_idx_d  = '0;
      end else if (recording_q) begin
        if (rec_store) begin
          rec_cnt_d = rec_cnt_q + CNT_W'(1);
          if (CMP_W'(rec_cnt_d) >= len) begin
            recording_d = 1'b0;
          end
        end else begin
          recording_d = 1'b0;
        end
      end else begin
        play_idx_d = play_cur + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_cnt_q   <= '0;
      recording_q <= 1'b1;
      play_idx_q  <= '0;
    end else begin
      rec_cnt_q   <= rec_cnt_d;
      recording_q <= recording_d;
      play_idx_q  <= play_idx_d;
    end
  end

  assign ram_we = accept && enable_q && recording_q && rec_store;
  assign ram_re = accept && enable_q && !recording_q;

  brl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (LOOP_DEPTH)
  ) u_loop_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rec_cnt_q[ADDR_W-1:0]),
    .wdata_i (in_ch.sample_in),
    .re_i    (ram_re),
    .raddr_i (play_cur[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign wet_eff = (wet_q > UNITY_GAIN) ? GAIN_EXT_W'(UNITY_GAIN) : GAIN_EXT_W'(wet_q);
  assign dry_eff = GAIN_EXT_W'(UNITY_GAIN) - wet_eff;

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign mix_sum = SUM_W'(s2_pwet_q) + SUM_W'(s2_pdry_q);

  // payload stages: memory read, multiply, sum
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_mix_q  <= enable_q && !recording_q;
      s1_live_q <= in_ch.sample_in;
      s1_wet_q  <= wet_eff;
      s1_dry_q  <= dry_eff;

      s2_mix_q  <= s1_mix_q;
      s2_live_q <= s1_live_q;
      s2_pwet_q <= PROD_W'(s1_live_q) * PROD_W'($signed({1'b0, s1_wet_q}));
      s2_pdry_q <= PROD_W'($signed(ram_rdata)) * PROD_W'($signed({1'b0, s1_dry_q}));

      out_q <= s2_mix_q ? mix_sum[GAIN_FRAC +: SAMPLE_BITS] : s2_live_q;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.sample_out = out_q;

endmodule

/* tb/beat_repeat_loop_tb.sv */
// Self-checking testbench for beat_repeat_loop: scripted and random samples
// against a cycle-free predictor of the stutter effect. Depends on brl_pkg,
// brl_in_if, brl_out_if and the beat_repeat_loop top level.
module beat_repeat_loop_tb;
  import brl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LOOP_DEPTH  = 1024;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned NUM_ROWS    = 39;
  localparam int unsigned IDLE_PCT    = 38;
  localparam int unsigned RANDOM_ITEMS = 800;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
    sample_t               smp;
    bit                    typed;
    sample_t               want;
  } script_row_t;

  typedef struct {
    sample_t smp;
    bit      typed;
    sample_t want;
  } request_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  brl_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  brl_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  beat_repeat_loop #(
    .LOOP_DEPTH (LOOP_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready = 1'b0;
  end

  // Effect state as the block should hold it.
  logic              fx_enable   = 1'b0;
  logic [DIV_W-1:0]  fx_division = DIV_RESET;
  logic [FPB_W-1:0]  fx_frames   = FPB_RESET;
  logic [GAIN_W-1:0] fx_wet      = WET_RESET;
  sample_t           loop_mem [LOOP_DEPTH];
  int unsigned       rec_count = 0;
  bit                rec_armed = 1'b1;
  int unsigned       play_pos  = 0;

  request_t    pending_requests [$];
  sample_t     awaited_samples [$];
  int unsigned errors = 0;
  int unsigned random_items = 0;
  bit          steady = 1'b0;
  int unsigned stall_requests = 0;
  int unsigned stalls_granted = 0;
  int unsigned stall_left = 0;

  function automatic sample_t next_sample_out(sample_t live);
    int unsigned span;
    int unsigned bound;
    longint      gain;
    longint      acc;
    span = 32'(fx_frames >> fx_division);
    if (span == 0) span = 1;
    if (!fx_enable) begin
      rec_armed = 1'b1;
      rec_count = 0;
      play_pos  = 0;
      return live;
    end
    if (rec_armed) begin
      if (rec_count < LOOP_DEPTH && rec_count < span) begin
        loop_mem[rec_count] = live;
        rec_count++;
        if (rec_count >= span) rec_armed = 1'b0;
      end else begin
        rec_armed = 1'b0;
      end
      return live;
    end
    bound = span;
    if (bound > LOOP_DEPTH) bound = LOOP_DEPTH;
    if (bound > rec_count) bound = rec_count;
    if (bound == 0) bound = 1;
    if (play_pos >= bound) play_pos = 0;
    gain = (fx_wet > UNITY_GAIN) ? longint'(UNITY_GAIN) : longint'(fx_wet);
    acc = longint'(live) * gain + longint'(loop_mem[play_pos]) * (longint'(UNITY_GAIN) - gain);
    play_pos++;
    return sample_t'(acc >>> GAIN_FRAC);
  endfunction

  function automatic sample_t any_sample();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    return sample_t'($urandom);
  endfunction

  function automatic logic [GAIN_W-1:0] any_gain();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5) return GAIN_W'($urandom_range(32768));
    if (pick < 7) begin
      case ($urandom_range(2))
        0: return '0;
        1: return UNITY_GAIN;
        default: return '1;
      endcase
    end
    return GAIN_W'($urandom);
  endfunction

  // Request side: hold valid until accepted, predict on acceptance.
  always @(posedge clk_i) begin : sender
    request_t req;
    sample_t  got;
    bit       offer;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        req = pending_requests.pop_front();
        got = next_sample_out(req.smp);
        awaited_samples.push_back(req.typed ? req.want : got);
        offer = 1'b0;
      end
      if (!offer && pending_requests.size() != 0 &&
          (steady || $urandom_range(99) >= IDLE_PCT)) begin
        offer = 1'b1;
        in_ch.sample_in <= pending_requests[0].smp;
      end
      in_ch.valid <= offer;
    end
  end

  // Result side: check in order, stall at random or on request.
  always @(posedge clk_i) begin : receiver
    sample_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_samples.size() == 0) begin
          $error("sample_out: expected none, got %0d", out_ch.sample_out);
          errors++;
        end else begin
          want = awaited_samples.pop_front();
          if (out_ch.sample_out !== want) begin
            $error("sample_out: expected %0d, got %0d", want, out_ch.sample_out);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (stalls_granted != stall_requests) begin
        stalls_granted++;
        stall_left = 300;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  task automatic settle();
    while (pending_requests.size() != 0 || awaited_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLE:   fx_enable   = data[0];
      CFG_DIVISION: fx_division = data[DIV_W-1:0];
      CFG_FPB:      fx_frames   = data[FPB_W-1:0];
      CFG_WET:      fx_wet      = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic feed(int unsigned n);
    request_t req;
    repeat (n) begin
      req.smp   = any_sample();
      req.typed = 1'b0;
      req.want  = '0;
      pending_requests.push_back(req);
    end
    random_items += n;
  endtask

  // Re-arm, record a fresh loop, then play it back.
  task automatic loop_phase();
    logic [FPB_W-1:0] frames;
    int unsigned      span;
    int unsigned      n;
    int unsigned      cut;
    int unsigned      pick;
    settle();
    write_reg(CFG_ENABLE, 0);
    feed($urandom_range(2));
    settle();
    pick = $urandom_range(99);
    if (pick < 85) frames = FPB_W'($urandom_range(1, 96));
    else if (pick < 95) frames = FPB_W'($urandom_range(97, 400));
    else frames = FPB_W'($urandom);
    write_reg(CFG_FPB, frames);
    write_reg(CFG_DIVISION, CFG_DATA_W'($urandom_range(3)));
    write_reg(CFG_WET, CFG_DATA_W'(any_gain()));
    write_reg(CFG_ENABLE, 1);
    span = 32'(fx_frames >> fx_division);
    if (span == 0) span = 1;
    n = (span > 400) ? $urandom_range(50, 200) : span + $urandom_range(1, span + 8);
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(1, n);
      feed(cut);
      settle();
      case ($urandom_range(2))
        0: write_reg(CFG_DIVISION, CFG_DATA_W'($urandom_range(3)));
        1: write_reg(CFG_FPB, CFG_DATA_W'($urandom_range(1, 96)));
        default: write_reg(CFG_WET, CFG_DATA_W'(any_gain()));
      endcase
      feed(n - cut);
    end else begin
      feed(n);
    end
  endtask

  task automatic noise_phase();
    settle();
    repeat ($urandom_range(1, 2)) write_reg(cfg_idx_e'($urandom_range(3)), CFG_DATA_W'($urandom));
    feed($urandom_range(1, 30));
  endtask

  initial begin
    script_row_t script [NUM_ROWS];
    request_t    req;
    bit          pressed;
    script = '{
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh8000, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh7FFF, 1'b1, 16'sh7FFF},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh0001, 1'b1, 16'sh0001},
      '{ROW_WRITE,  CFG_FPB,      3,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_WRITE,  CFG_DIVISION, 2,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_WRITE,  CFG_ENABLE,   1,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh1234, 1'b1, 16'sh1234},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh8000, 1'b1, 16'sh8000},
      '{ROW_WRITE,  CFG_WET,      0,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh7FFF, 1'b1, 16'sh1234},
      '{ROW_WRITE,  CFG_WET,      65535,  16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'shABCD, 1'b1, 16'shABCD},
      '{ROW_WRITE,  CFG_ENABLE,   0,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh5555, 1'b1, 16'sh5555},
      '{ROW_WRITE,  CFG_FPB,      262143, 16'sh0000, 1'b0, 16'sh0000},
      '{ROW_WRITE,  CFG_DIVISION, 3,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_WRITE,  CFG_ENABLE,   1,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh7FFF, 1'b1, 16'sh7FFF},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh8000, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh0000, 1'b1, 16'sh0000},
      '{ROW_WRITE,  CFG_FPB,      2,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_WRITE,  CFG_DIVISION, 0,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh1111, 1'b1, 16'sh1111},
      '{ROW_WRITE,  CFG_WET,      16384,  16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh7FFF, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh8000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh4321, 1'b0, 16'sh0000},
      '{ROW_WRITE,  CFG_WET,      1,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh0100, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'shC000, 1'b0, 16'sh0000},
      '{ROW_WRITE,  CFG_ENABLE,   0,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'shFFFF, 1'b1, 16'shFFFF},
      '{ROW_WRITE,  CFG_FPB,      0,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_WRITE,  CFG_DIVISION, 3,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_WRITE,  CFG_WET,      32767,  16'sh0000, 1'b0, 16'sh0000},
      '{ROW_WRITE,  CFG_ENABLE,   1,      16'sh0000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh4000, 1'b1, 16'sh4000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh8000, 1'b0, 16'sh0000},
      '{ROW_SAMPLE, CFG_ENABLE,   0,      16'sh7FFF, 1'b0, 16'sh0000}
    };
    pressed = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        req.smp   = script[i].smp;
        req.typed = script[i].typed;
        req.want  = script[i].want;
        pending_requests.push_back(req);
      end
    end

    steady = 1'b1;
    while (random_items < RANDOM_ITEMS || !pressed) begin
      if (random_items >= 200) steady = 1'b0;
      if (!pressed && random_items >= 400) begin
        // hold results back while requests keep coming
        settle();
        stall_requests++;
        feed(120);
        pressed = 1'b1;
      end
      if ($urandom_range(99) < 80) loop_phase();
      else noise_phase();
    end

    // fill the whole store, then shrink the loop under the play position
    settle();
    write_reg(CFG_ENABLE, 0);
    write_reg(CFG_FPB, 40000);
    write_reg(CFG_DIVISION, 0);
    write_reg(CFG_WET, CFG_DATA_W'(any_gain()));
    write_reg(CFG_ENABLE, 1);
    feed(LOOP_DEPTH + 1 + 20);
    settle();
    write_reg(CFG_DIVISION, 3);
    write_reg(CFG_FPB, 16);
    feed(20);

    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && awaited_samples.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
src/brl_pkg.sv
src/brl_in_if.sv
src/brl_out_if.sv
src/brl_ram.sv
src/beat_repeat_loop.sv
tb/beat_repeat_loop_tb.sv
